/* design/lsm_pkg.sv */
// Shared types and constants for the LCG seed letter match unit.
package lsm_pkg;

  localparam int unsigned SEED_W     = 36;
  localparam int unsigned LETTER_W   = 5;
  localparam int unsigned DEPTH_W    = 5;
  localparam int unsigned REG_W      = 50;
  localparam int unsigned MAX_LENGTH = 20;
  localparam int unsigned HALF_W     = SEED_W / 2;

  localparam logic [SEED_W-1:0] LCG_MUL = 36'd17059465;
  localparam logic [SEED_W-1:0] LCG_INV = 36'd67451848633;
  localparam logic [SEED_W-1:0] LETTER_SPAN = 36'd26;

  localparam logic [HALF_W-1:0] INV_LO = LCG_INV[HALF_W-1:0];
  localparam logic [HALF_W-1:0] INV_HI = LCG_INV[SEED_W-1:HALF_W];

  typedef enum logic {
    REG_TARGET_LOW  = 1'b0,
    REG_TARGET_HIGH = 1'b1
  } lsm_reg_idx_t;

  typedef struct packed {
    logic [SEED_W-1:0]  seed;
    logic [SEED_W-1:0]  x;
    logic [DEPTH_W-1:0] depth;
  } lsm_token_t;

  typedef struct packed {
    logic               matched;
    logic [DEPTH_W-1:0] depth;
    logic [SEED_W-1:0]  prev_seed;
  } lsm_result_t;

endpackage

/* design/lsm_cell.sv */
// One letter cell of the chain: compares one letter and steps the generator once.
module lsm_cell
  import lsm_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  lsm_token_t          up_tok,
  input  logic [LETTER_W-1:0] target_letter,
  output logic                dn_valid,
  input  logic                dn_ready,
  output lsm_token_t          dn_tok
);

  localparam logic [DEPTH_W-1:0] STEP_DEPTH = DEPTH_W'(STEP + 1);

  logic                     valid_r;
  lsm_token_t               tok_r;
  lsm_token_t               tok_nxt;
  logic [SEED_W+LETTER_W-1:0] letter_prod;
  logic [LETTER_W-1:0]      letter;

  always_comb begin
    letter_prod = {{LETTER_W{1'b0}}, up_tok.x} * {{LETTER_W{1'b0}}, LETTER_SPAN};
    letter      = letter_prod[SEED_W+LETTER_W-1:SEED_W];
    tok_nxt     = up_tok;
    tok_nxt.x   = up_tok.x * LCG_MUL + {{(SEED_W-1){1'b0}}, 1'b1};
    if (up_tok.depth == '0 && letter != target_letter) begin
      tok_nxt.depth = STEP_DEPTH;
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_tok   = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

/* design/lsm_inv_step.sv */
// Two-stage inverse generator step and result register at the end of the chain.
module lsm_inv_step
  import lsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  lsm_token_t  up_tok,
  output logic        dn_valid,
  input  logic        dn_ready,
  output lsm_result_t dn_res
);

  logic               valid_a_r;
  logic [SEED_W-1:0]  p_lo_r;
  logic [HALF_W-1:0]  p_hi_r;
  logic [DEPTH_W-1:0] depth_a_r;
  logic               valid_b_r;
  lsm_result_t        res_r;
  logic               ready_a;
  logic               ready_b;
  logic [SEED_W-1:0]  dec_seed;
  logic [SEED_W-1:0]  p_lo_nxt;
  logic [HALF_W-1:0]  p_hi_nxt;
  lsm_result_t        res_nxt;

  always_comb begin
    dec_seed = up_tok.seed - {{(SEED_W-1){1'b0}}, 1'b1};
    p_lo_nxt = dec_seed * {{(SEED_W-HALF_W){1'b0}}, INV_LO};
    p_hi_nxt = dec_seed[HALF_W-1:0] * INV_HI;
  end

  always_comb begin
    res_nxt.matched   = (depth_a_r == '0);
    res_nxt.depth     = depth_a_r;
    res_nxt.prev_seed = p_lo_r + {p_hi_r, {HALF_W{1'b0}}};
  end

  assign ready_b  = !valid_b_r || dn_ready;
  assign ready_a  = !valid_a_r || ready_b;
  assign up_ready = ready_a;
  assign dn_valid = valid_b_r;
  assign dn_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a_r <= up_valid;
      end
      if (ready_b) begin
        valid_b_r <= valid_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && up_valid) begin
      p_lo_r    <= p_lo_nxt;
      p_hi_r    <= p_hi_nxt;
      depth_a_r <= up_tok.depth;
    end
    if (ready_b && valid_a_r) begin
      res_r <= res_nxt;
    end
  end

endmodule

/* design/lcg_seed_letter_match_unit.sv */
// Top level of the LCG seed letter match unit: target registers, cell chain and result stage.
// Each candidate seed runs down a chain of TARGET_LENGTH letter cells, one cell per target
// position from the last letter back to the first, each cell doing one generator multiply and
// one letter compare per cycle unless stalled, followed by a two-stage inverse step whose second
// stage is the output register. One word is accepted per cycle unless the chain stalls; its result
// passes through every cell register and both inverse stages, the second of which offers it. Every
// stage holds its own word, so empty stages fill while a result waits to be taken.
module lcg_seed_letter_match_unit
  import lsm_pkg::*;
#(
  parameter int unsigned TARGET_LENGTH = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SEED_W-1:0]  in_candidate_seed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_matched,
  output logic [DEPTH_W-1:0] out_mismatch_depth,
  output logic [SEED_W-1:0]  out_previous_seed,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [REG_W-1:0]   cfg_wdata
);

  logic [REG_W-1:0]       target_low_r;
  logic [REG_W-1:0]       target_high_r;
  logic [2*REG_W-1:0]     targets;
  logic [TARGET_LENGTH:0] chain_valid;
  logic [TARGET_LENGTH:0] chain_ready;
  lsm_token_t             chain_tok [TARGET_LENGTH+1];
  lsm_result_t            res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_low_r  <= '0;
      target_high_r <= '0;
    end else if (cfg_we) begin
      unique case (lsm_reg_idx_t'(cfg_index))
        REG_TARGET_LOW:  target_low_r  <= cfg_wdata;
        REG_TARGET_HIGH: target_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign targets = {target_high_r, target_low_r};

  assign chain_valid[0]    = in_valid;
  assign in_ready          = chain_ready[0];
  assign chain_tok[0].seed = in_candidate_seed;
  assign chain_tok[0].x    = in_candidate_seed;
  assign chain_tok[0].depth = '0;

  for (genvar k = 0; k < TARGET_LENGTH; k++) begin : g_cell
    localparam int unsigned POS = TARGET_LENGTH - 1 - k;
    lsm_cell #(
      .STEP(k)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .up_valid     (chain_valid[k]),
      .up_ready     (chain_ready[k]),
      .up_tok       (chain_tok[k]),
      .target_letter(targets[POS*LETTER_W +: LETTER_W]),
      .dn_valid     (chain_valid[k+1]),
      .dn_ready     (chain_ready[k+1]),
      .dn_tok       (chain_tok[k+1])
    );
  end

  lsm_inv_step u_inv (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(chain_valid[TARGET_LENGTH]),
    .up_ready(chain_ready[TARGET_LENGTH]),
    .up_tok  (chain_tok[TARGET_LENGTH]),
    .dn_valid(out_valid),
    .dn_ready(out_ready),
    .dn_res  (res)
  );

  assign out_matched        = res.matched;
  assign out_mismatch_depth = res.depth;
  assign out_previous_seed  = res.prev_seed;

  a_match_depth_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_matched |-> out_mismatch_depth == '0)
    else $error("Matched word carries a non-zero mismatch depth.");

  a_depth_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |->
      out_mismatch_depth != '0 && out_mismatch_depth <= DEPTH_W'(TARGET_LENGTH))
    else $error("Mismatch depth outside the target length.");

  a_empty_head_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !chain_valid[1] |-> in_ready)
    else $error("Input refused although the first cell is empty.");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the LCG seed letter match unit, with a seed verdict scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import lsm_pkg::*;

  localparam int unsigned WORD_LEN   = 20;
  localparam int unsigned LATENCY    = WORD_LEN + 2;
  localparam int unsigned PHASES     = 12;
  localparam int unsigned PER_PHASE  = 150;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam bit [35:0] STEP_MUL     = 36'd17059465;
  localparam bit [35:0] STEP_INV     = 36'd67451848633;
  localparam bit [35:0] SEED_MAX     = 36'hFFFFFFFFF;
  localparam bit [49:0] CODES_ALL_HI = {50{1'b1}};

  class seed_verdict_book;
    typedef struct {
      bit        matched;
      bit [4:0]  depth;
      bit [35:0] prev;
    } verdict_t;

    bit [49:0]   letters_low;
    bit [49:0]   letters_high;
    verdict_t    awaited[$];
    int unsigned fail_count;

    function bit [4:0] letter_of(bit [35:0] x);
      bit [41:0] prod;
      prod = {6'd0, x} * 42'd26;
      return prod[40:36];
    endfunction

    function bit [35:0] step_on(bit [35:0] x);
      return x * STEP_MUL + 36'd1;
    endfunction

    function void set_target(lsm_reg_idx_t idx, bit [49:0] value);
      if (idx == REG_TARGET_LOW) letters_low = value;
      else letters_high = value;
    endfunction

    function void note_seed(bit [35:0] seed);
      verdict_t  v;
      bit [35:0] x;
      bit [99:0] all;
      bit [4:0]  checked;
      all     = {letters_high, letters_low};
      x       = seed;
      checked = 0;
      v.depth = 0;
      for (int pos = WORD_LEN - 1; pos >= 0; pos--) begin
        checked++;
        if (letter_of(x) != all[pos*5 +: 5]) begin
          v.depth = checked;
          break;
        end
        x = step_on(x);
      end
      v.matched = (v.depth == 0);
      v.prev    = (seed - 36'd1) * STEP_INV;
      awaited.push_back(v);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      fail_count++;
      if (fail_count <= 200)
        $display("tb: mismatch in %s: got %0h, expected %0h", what, got, want);
    endtask

    task check_result(logic m, logic [4:0] d, logic [35:0] p);
      verdict_t want;
      if (awaited.size() == 0) begin
        report_mismatch("unawaited result", p, 0);
        return;
      end
      want = awaited.pop_front();
      if (m !== want.matched) report_mismatch("matched", m, want.matched);
      if (d !== want.depth) report_mismatch("mismatch_depth", d, want.depth);
      if (p !== want.prev) report_mismatch("previous_seed", p, want.prev);
    endtask

    task flag_leftover();
      if (awaited.size() != 0) report_mismatch("undelivered results", 0, awaited.size());
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [SEED_W-1:0]  in_candidate_seed = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_matched;
  logic [DEPTH_W-1:0] out_mismatch_depth;
  logic [SEED_W-1:0]  out_previous_seed;
  logic               cfg_we = 1'b0;
  logic               cfg_index = REG_TARGET_LOW;
  logic [REG_W-1:0]   cfg_wdata = '0;

  seed_verdict_book book;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  int unsigned      stall_pending = 0;
  int unsigned      stall_cycles = 0;
  int unsigned      cycle_count = 0;

  lcg_seed_letter_match_unit #(.TARGET_LENGTH(WORD_LEN)) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_candidate_seed  (in_candidate_seed),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_matched        (out_matched),
    .out_mismatch_depth (out_mismatch_depth),
    .out_previous_seed  (out_previous_seed),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_cycles != 0) begin
      out_ready <= 1'b0;
      stall_cycles = stall_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      book.check_result(out_matched, out_mismatch_depth, out_previous_seed);
  end

  function bit [35:0] rand_seed();
    bit [63:0] r;
    r = {$urandom, $urandom};
    return r[35:0];
  endfunction

  function bit [49:0] rand_word();
    bit [63:0] r;
    r = {$urandom, $urandom};
    return r[49:0];
  endfunction

  function bit [99:0] letters_from(bit [35:0] seed);
    bit [99:0] all;
    bit [35:0] x;
    x = seed;
    for (int pos = WORD_LEN - 1; pos >= 0; pos--) begin
      all[pos*5 +: 5] = book.letter_of(x);
      x = book.step_on(x);
    end
    return all;
  endfunction

  function bit [35:0] pick_seed(bit [35:0] key);
    int unsigned kind;
    bit [35:0]   mask;
    kind = $urandom_range(0, 9);
    mask = rand_seed() >> $urandom_range(0, 35);
    case (kind)
      0, 1:          return key;
      2, 3, 4, 5, 6: return key ^ mask;
      7:             return key + $urandom_range(1, 64);
      default:       return rand_seed();
    endcase
  endfunction

  // Entered and left just after a falling edge.
  task send_seed(bit [35:0] seed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_candidate_seed <= seed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_seed(seed);
    if (stall_pending != 0) begin
      stall_cycles  = stall_pending;
      stall_pending = 0;
    end
    @(negedge clk);
  endtask

  task drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (book.awaited.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task write_targets(bit [49:0] low_word, bit [49:0] high_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TARGET_LOW;
    cfg_wdata <= low_word;
    book.set_target(REG_TARGET_LOW, low_word);
    @(negedge clk);
    cfg_index <= REG_TARGET_HIGH;
    cfg_wdata <= high_word;
    book.set_target(REG_TARGET_HIGH, high_word);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    bit [35:0] key;
    bit [99:0] letters;

    book = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Targets still at their reset value.
    send_seed(36'd0);
    send_seed(SEED_MAX);
    send_seed(36'd1);
    drain_results();

    // Codes of 31 everywhere can never be generated.
    write_targets(CODES_ALL_HI, CODES_ALL_HI);
    send_seed(36'd0);
    send_seed(SEED_MAX);
    drain_results();

    letters = letters_from(36'd0);
    write_targets(letters[49:0], letters[99:50]);
    send_seed(36'd0);
    send_seed(SEED_MAX);
    drain_results();

    key     = rand_seed();
    letters = letters_from(key);
    write_targets(letters[49:0], letters[99:50]);
    send_seed(key);
    send_seed(key ^ 36'd1);
    send_seed(key ^ 36'h800000000);
    send_seed(36'd0);
    send_seed(SEED_MAX);
    drain_results();

    letters[4:0] = 5'd26;
    write_targets(letters[49:0], letters[99:50]);
    send_seed(key);
    send_seed(key ^ 36'd2);
    drain_results();

    letters = letters_from(key);
    letters[54:50] = 5'd31;
    write_targets(letters[49:0], letters[99:50]);
    send_seed(key);
    drain_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 4) begin
        send_idle_pct = 35;
        recv_idle_pct = 53;
      end else if (phase < 8) begin
        send_idle_pct = 53;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      key     = rand_seed();
      letters = letters_from(key);
      case (phase % 4)
        1: letters[$urandom_range(0, WORD_LEN - 1)*5 +: 5] = 5'($urandom_range(0, 31));
        2: letters = {rand_word(), rand_word()};
        default: ;
      endcase
      write_targets(letters[49:0], letters[99:50]);
      for (int k = 0; k < PER_PHASE; k++) begin
        if (phase == 1 && k == 60) stall_pending = 300;
        if (phase == 9 && k == 40) stall_pending = 250;
        if (phase == 5 && k == 75) drain_results();
        send_seed(pick_seed(key));
      end
      drain_results();
    end

    book.flag_leftover();
    if (book.fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/lsm_pkg.sv
design/lsm_cell.sv
design/lsm_inv_step.sv
design/lcg_seed_letter_match_unit.sv
tb/tb_top.sv
